// File: rtl/core/vumph_pkg.sv
package vumph_pkg;

  // Defaults for the top-level parameters
  localparam int NumLedsDef     = 18;
  localparam int NumChannelsDef = 2;

  // Segment index width; a column never exceeds 32 segments
  localparam int SegW = 5;
  // Signed top of column or peak dot, -1 means nothing lit
  localparam int TopW = SegW + 1;

  // dB to segment mapping: (level + DbOffset) / 3
  localparam int DbOffset = 45 + 3;
  // Divide by three as (x * Div3Mul) >> Div3Shift, exact for x below 256
  localparam int Div3Mul   = 171;
  localparam int Div3Shift = 9;

  localparam int OrangeAbove = 14;
  localparam int RedAbove    = 16;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegMode     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPeakHold = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPeakStep = 2'd2;

  localparam int CfgDataW = 16;
  localparam logic [CfgDataW-1:0] PeakHoldRst = 16'd1000;
  localparam logic [CfgDataW-1:0] PeakStepRst = 16'd50;

  // Colour classes
  localparam logic [1:0] ColBg     = 2'd0;
  localparam logic [1:0] ColGreen  = 2'd1;
  localparam logic [1:0] ColOrange = 2'd2;
  localparam logic [1:0] ColRed    = 2'd3;

  // Queued item after classification
  typedef struct packed {
    logic            channel;
    logic [SegW-1:0] target;
    logic [31:0]     time_ms;
  } item_t;

  // One draw command
  typedef struct packed {
    logic            channel;
    logic [SegW-1:0] segment;
    logic            lit;
    logic [1:0]      colour;
  } cmd_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic                mode;
    logic [CfgDataW-1:0] hold_ms;
    logic [CfgDataW-1:0] step_ms;
    logic                clear_tops;
  } cfg_t;

  function automatic cmd_t make_cmd(input logic channel, input logic signed [TopW-1:0] seg,
                                    input logic on);
    cmd_t c;
    c.channel = channel;
    c.segment = seg[SegW-1:0];
    c.lit     = on;
    if (!on) begin
      c.colour = ColBg;
    end else if (seg > TopW'(RedAbove)) begin
      c.colour = ColRed;
    end else if (seg > TopW'(OrangeAbove)) begin
      c.colour = ColOrange;
    end else begin
      c.colour = ColGreen;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/vumph_front.sv
module vumph_front #(
  parameter int NUM_LEDS     = 18,
  parameter int NUM_CHANNELS = 2
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  channel_i,
  input  logic signed [7:0]     level_db_i,
  input  logic [31:0]           time_ms_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output vumph_pkg::item_t      q_item_o
);
  import vumph_pkg::*;

  logic signed [8:0] sum;
  logic [15:0]       prod;
  logic [6:0]        quot;
  logic [SegW-1:0]   target;
  logic              ch_ok;

  // Map dB to target segment, clamp at both ends
  assign sum  = $signed({level_db_i[7], level_db_i}) + 9'sd48;
  assign prod = 16'(sum[7:0]) * 16'(Div3Mul);
  assign quot = prod[15:Div3Shift];

  always_comb begin
    if (sum[8]) begin
      target = '0;
    end else if (quot > 7'(NUM_LEDS - 1)) begin
      target = SegW'(NUM_LEDS - 1);
    end else begin
      target = quot[SegW-1:0];
    end
  end

  // Items for channels that do not exist are taken and dropped
  assign ch_ok      = int'(channel_i) < NUM_CHANNELS;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && ch_ok;

  assign q_item_o.channel = channel_i;
  assign q_item_o.target  = target;
  assign q_item_o.time_ms = time_ms_i;

endmodule

// File: rtl/core/vumph_queue.sv
module vumph_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vumph_pkg::item_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output vumph_pkg::item_t data_o,
  output logic             valid_o
);
  import vumph_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/vumph_back.sv
module vumph_back #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vumph_pkg::cfg_t  cfg_i,
  input  logic             item_valid_i,
  input  vumph_pkg::item_t item_i,
  output logic             item_pop_o,
  output logic             cmd_valid_o,
  output vumph_pkg::cmd_t  cmd_o,
  output logic             cmd_last_o,
  input  logic             cmd_stall_i
);
  import vumph_pkg::*;

  localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Per-channel meter state
  logic signed [TopW-1:0] col_q   [NUM_CHANNELS];
  logic signed [TopW-1:0] pk_q    [NUM_CHANNELS];
  logic [31:0]            stamp_q [NUM_CHANNELS];
  logic                   hold_q  [NUM_CHANNELS];

  // Command buffer, up to three per item
  cmd_t       cmd_q [3];
  logic [1:0] cnt_q;
  logic [1:0] rd_q;

  logic [ChW-1:0]         ch_idx;
  logic signed [TopW-1:0] col, pk, tgt, col_new, pk_new;
  logic                   col_up, col_dn;
  logic                   a_en, pk_catch, pk_fall, light_pk;
  logic [31:0]            elapsed, limit;
  cmd_t                   cmd_a, cmd_b, cmd_c;
  cmd_t                   slot [3];
  logic [1:0]             n_cmd;
  logic                   out_fire, buf_free;

  assign ch_idx = ChW'(item_i.channel);
  assign col    = col_q[ch_idx];
  assign pk     = pk_q[ch_idx];
  assign tgt    = $signed({1'b0, item_i.target});

  // Column moves one step toward the target
  assign col_up  = tgt > col;
  assign col_dn  = tgt < col;
  assign col_new = col_up ? col + 6'sd1 : (col_dn ? col - 6'sd1 : col);
  // In peak mode the dot segment stays lit as the column falls through it
  assign a_en    = col_up || (col_dn && !(cfg_i.mode && col == pk));

  // Peak dot
  assign elapsed  = item_i.time_ms - stamp_q[ch_idx];
  assign limit    = hold_q[ch_idx] ? 32'(cfg_i.hold_ms) : 32'(cfg_i.step_ms);
  assign pk_catch = cfg_i.mode && (col_new >= pk);
  assign pk_fall  = cfg_i.mode && !pk_catch && (elapsed > limit);
  assign pk_new   = pk - 6'sd1;
  assign light_pk = pk_fall && (col_new != pk_new);

  assign cmd_a = col_up ? make_cmd(item_i.channel, col_new, 1'b1)
                        : make_cmd(item_i.channel, col, 1'b0);
  assign cmd_b = make_cmd(item_i.channel, pk, 1'b0);
  assign cmd_c = make_cmd(item_i.channel, pk_new, 1'b1);

  // Pack commands in order: column, peak clear, peak light
  assign slot[0] = a_en ? cmd_a : cmd_b;
  assign slot[1] = a_en ? cmd_b : cmd_c;
  assign slot[2] = cmd_c;
  assign n_cmd   = 2'(a_en) + 2'(pk_fall) + 2'(light_pk);

  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = cmd_q[rd_q];
  assign cmd_last_o  = rd_q == cnt_q - 2'd1;
  assign out_fire    = cmd_valid_o && !cmd_stall_i;
  // Next item may load as the last command of the current one leaves
  assign buf_free    = !cmd_valid_o || (out_fire && cmd_last_o);
  assign item_pop_o  = item_valid_i && buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else if (item_pop_o) begin
      cnt_q <= n_cmd;
      rd_q  <= 2'd0;
    end else if (out_fire) begin
      if (cmd_last_o) begin
        cnt_q <= 2'd0;
        rd_q  <= 2'd0;
      end else begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      for (int i = 0; i < 3; i++) begin
        cmd_q[i] <= slot[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        col_q[i]   <= -6'sd1;
        pk_q[i]    <= -6'sd1;
        stamp_q[i] <= '0;
        hold_q[i]  <= 1'b0;
      end
    end else if (cfg_i.clear_tops) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        col_q[i] <= -6'sd1;
        pk_q[i]  <= -6'sd1;
      end
    end else if (item_pop_o) begin
      col_q[ch_idx] <= col_new;
      if (pk_catch) begin
        pk_q[ch_idx]    <= col_new;
        stamp_q[ch_idx] <= item_i.time_ms;
        hold_q[ch_idx]  <= 1'b1;
      end else if (pk_fall) begin
        pk_q[ch_idx]    <= pk_new;
        stamp_q[ch_idx] <= item_i.time_ms;
        hold_q[ch_idx]  <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/vu_meter_peak_hold.sv
// An item taken at the input is written into the queue, then popped into the command
//   buffer once that is free; its first draw command is offered from the buffer.
// Throughput: one item per cycle if it draws at most one segment and out_stall_i is low;
//   an item drawing more (up to 3) keeps the single command port until its last leaves.
// Reset: mode 0, peak hold 1000 ms, peak step 50 ms, all tops at -1, peak stamps and
//   hold flags zero, queue and command buffer empty. No clearing pass.
module vu_meter_peak_hold #(
  parameter int NUM_LEDS     = vumph_pkg::NumLedsDef,
  parameter int NUM_CHANNELS = vumph_pkg::NumChannelsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [vumph_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [vumph_pkg::CfgDataW-1:0]       cfg_data_i,
  // Input items
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 channel_i,
  input  logic signed [7:0]                    level_db_i,
  input  logic [31:0]                          time_ms_i,
  // Draw commands
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 draw_channel_o,
  output logic [vumph_pkg::SegW-1:0]           draw_segment_o,
  output logic                                 lit_o,
  output logic [1:0]                           colour_o,
  output logic                                 last_o
);
  import vumph_pkg::*;

  // Config registers. Writes must arrive only while the meter is idle; not enforced.
  logic                mode_q;
  logic [CfgDataW-1:0] hold_ms_q;
  logic [CfgDataW-1:0] step_ms_q;
  cfg_t                cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      hold_ms_q <= PeakHoldRst;
      step_ms_q <= PeakStepRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:     mode_q    <= cfg_data_i[0];
        RegPeakHold: hold_ms_q <= cfg_data_i;
        RegPeakStep: step_ms_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Any mode write drops both tops of every channel back to -1
  assign cfg.mode       = mode_q;
  assign cfg.hold_ms    = hold_ms_q;
  assign cfg.step_ms    = step_ms_q;
  assign cfg.clear_tops = cfg_we_i && (cfg_index_i == RegMode);

  // Front: map dB to a target segment, drop unknown channels, feed the queue
  logic  q_full, q_push, q_valid, q_pop;
  item_t q_in, q_out;

  vumph_front #(
    .NUM_LEDS     (NUM_LEDS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .channel_i  (channel_i),
    .level_db_i (level_db_i),
    .time_ms_i  (time_ms_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  // Two-entry queue lets the front keep taking items while the back drains
  vumph_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .valid_o (q_valid)
  );

  // Back: column step, peak dot update, command buffer on the output side
  cmd_t cmd;

  vumph_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .cmd_valid_o  (out_valid_o),
    .cmd_o        (cmd),
    .cmd_last_o   (last_o),
    .cmd_stall_i  (out_stall_i)
  );

  assign draw_channel_o = cmd.channel;
  assign draw_segment_o = cmd.segment;
  assign lit_o          = cmd.lit;
  assign colour_o       = cmd.colour;

  // Commands of one item leave without gaps
  a_burst_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a command burst");

  // A lit segment always carries a colour, a cleared one never does
  a_colour_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lit_o == (colour_o != ColBg)))
    else $error("colour class does not match lit");

  // Drawn segments stay on the bar
  a_segment_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(draw_segment_o) < NUM_LEDS))
    else $error("segment beyond bar");

endmodule

// File: tb/vumph_checker.sv
`timescale 1ns / 1ps

// Watches the item, config and draw channels of the VU meter, predicts the
// draw commands of each accepted item and compares them in order.
module vumph_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vumph_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [vumph_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          channel_i,
  input  logic signed [7:0]             level_db_i,
  input  logic [31:0]                   time_ms_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          draw_channel_i,
  input  logic [vumph_pkg::SegW-1:0]    draw_segment_i,
  input  logic                          lit_i,
  input  logic [1:0]                    colour_i,
  input  logic                          last_i,
  output int                            mismatch_cnt_o,
  output int                            pending_o
);
  import vumph_pkg::*;

  localparam int NumCh = NumChannelsDef;

  typedef struct packed {
    cmd_t cmd;
    logic last;
  } draw_t;

  // meter settings, and meter state per channel
  logic                   mode_q;
  logic [CfgDataW-1:0]    hold_q;
  logic [CfgDataW-1:0]    step_q;
  logic signed [TopW-1:0] col_top    [NumCh];
  logic signed [TopW-1:0] pk_top     [NumCh];
  logic [31:0]            pk_stamp   [NumCh];
  logic                   pk_holding [NumCh];

  draw_t draw_q[$];
  int    errs;

  function automatic draw_t mk_draw(input logic ch, input logic signed [TopW-1:0] seg,
                                    input logic on);
    draw_t d;
    d.cmd.channel = ch;
    d.cmd.segment = seg[SegW-1:0];
    d.cmd.lit     = on;
    d.last        = 1'b0;
    if (!on) begin
      d.cmd.colour = ColBg;
    end else if (seg > RedAbove) begin
      d.cmd.colour = ColRed;
    end else if (seg > OrangeAbove) begin
      d.cmd.colour = ColOrange;
    end else begin
      d.cmd.colour = ColGreen;
    end
    return d;
  endfunction

  // Column step, then peak dot update; queues the draws of one item
  task automatic step_meter(input logic ch, input logic signed [7:0] lvl,
                            input logic [31:0] now);
    int          sum;
    int          tgt;
    logic [31:0] elapsed;
    logic [31:0] limit;
    draw_t       batch[$];
    draw_t       d;
    sum = int'(lvl) + DbOffset;
    tgt = (sum < 0) ? 0 : sum / 3;
    if (tgt > NumLedsDef - 1) tgt = NumLedsDef - 1;

    if (tgt > col_top[ch]) begin
      col_top[ch] = col_top[ch] + 6'sd1;
      batch.push_back(mk_draw(ch, col_top[ch], 1'b1));
    end else if (tgt < col_top[ch]) begin
      // the peak dot keeps its segment lit when the column drops off it
      if (!(mode_q && col_top[ch] == pk_top[ch]))
        batch.push_back(mk_draw(ch, col_top[ch], 1'b0));
      col_top[ch] = col_top[ch] - 6'sd1;
    end

    if (mode_q) begin
      if (col_top[ch] >= pk_top[ch]) begin
        pk_top[ch]     = col_top[ch];
        pk_stamp[ch]   = now;
        pk_holding[ch] = 1'b1;
      end else begin
        elapsed = now - pk_stamp[ch];
        limit   = pk_holding[ch] ? 32'(hold_q) : 32'(step_q);
        if (elapsed > limit) begin
          pk_stamp[ch]   = now;
          pk_holding[ch] = 1'b0;
          batch.push_back(mk_draw(ch, pk_top[ch], 1'b0));
          pk_top[ch] = pk_top[ch] - 6'sd1;
          if (col_top[ch] != pk_top[ch])
            batch.push_back(mk_draw(ch, pk_top[ch], 1'b1));
        end
      end
    end

    if (batch.size() > 0) begin
      d = batch.pop_back();
      d.last = 1'b1;
      batch.push_back(d);
      foreach (batch[i]) draw_q.push_back(batch[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t got;
    draw_t exp;
    if (!rst_ni) begin
      mode_q = 1'b0;
      hold_q = PeakHoldRst;
      step_q = PeakStepRst;
      for (int c = 0; c < NumCh; c++) begin
        col_top[c]    = -6'sd1;
        pk_top[c]     = -6'sd1;
        pk_stamp[c]   = '0;
        pk_holding[c] = 1'b0;
      end
      draw_q.delete();
      errs = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      // draws first, so an item taken this edge cannot match an earlier draw
      if (out_valid_i && !out_stall_i) begin
        got.cmd.channel = draw_channel_i;
        got.cmd.segment = draw_segment_i;
        got.cmd.lit     = lit_i;
        got.cmd.colour  = colour_i;
        got.last        = last_i;
        if (draw_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected draw ch=%0d seg=%0d lit=%0d col=%0d last=%0d", $time,
                     got.cmd.channel, got.cmd.segment, got.cmd.lit, got.cmd.colour, got.last);
          errs++;
        end else begin
          exp = draw_q.pop_front();
          if (got.cmd.channel !== exp.cmd.channel || got.cmd.segment !== exp.cmd.segment ||
              got.cmd.lit !== exp.cmd.lit || got.cmd.colour !== exp.cmd.colour ||
              got.last !== exp.last) begin
            // fields in order ch/seg/lit/col/last
            if (errs < 10)
              $display("%0t: draw differs: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                       $time, exp.cmd.channel, exp.cmd.segment, exp.cmd.lit, exp.cmd.colour,
                       exp.last, got.cmd.channel, got.cmd.segment, got.cmd.lit,
                       got.cmd.colour, got.last);
            errs++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMode: begin
            mode_q = cfg_data_i[0];
            for (int c = 0; c < NumCh; c++) begin
              col_top[c] = -6'sd1;
              pk_top[c]  = -6'sd1;
            end
          end
          RegPeakHold: hold_q = cfg_data_i;
          RegPeakStep: step_q = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i)
        step_meter(channel_i, level_db_i, time_ms_i);

      mismatch_cnt_o <= errs;
      pending_o      <= draw_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the VU meter. Items go in at the falling edge, a
// checker beside the block predicts and compares every draw command.
module tb_top;
  import vumph_pkg::*;

  // no register sits at this index; writes to it must do nothing
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam int LongHold   = 120;   // receiver hold-off for the fill-up phase
  localparam int SettleCyc  = 32;    // drain of items that draw nothing
  localparam int QuietLimit = 3000;  // cycles with no handshake before giving up

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                channel_i;
  logic signed [7:0]   level_db_i;
  logic [31:0]         time_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                draw_channel_o;
  logic [SegW-1:0]     draw_segment_o;
  logic                lit_o;
  logic [1:0]          colour_o;
  logic                last_o;

  int mismatch_cnt;
  int pending;

  // idling controls, changed only between phases
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;       // bumped to ask the receiver for one long hold-off

  // random walk state of the item generator
  logic        walk_ch;
  int          lvl_walk;
  logic [31:0] now_ms;

  int quiet_cycles;

  vu_meter_peak_hold dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .channel_i      (channel_i),
    .level_db_i     (level_db_i),
    .time_ms_i      (time_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .draw_channel_o (draw_channel_o),
    .draw_segment_o (draw_segment_o),
    .lit_o          (lit_o),
    .colour_o       (colour_o),
    .last_o         (last_o)
  );

  vumph_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .channel_i      (channel_i),
    .level_db_i     (level_db_i),
    .time_ms_i      (time_ms_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .draw_channel_i (draw_channel_o),
    .draw_segment_i (draw_segment_o),
    .lit_i          (lit_o),
    .colour_i       (colour_o),
    .last_i         (last_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stall each cycle, or one long hold-off when asked.
  // The long one lets the block back up into its input queue.
  initial begin
    int hold_seen;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen   = hold_req;
        out_stall_i = 1'b1;
        repeat (LongHold - 1) @(negedge clk_i);
      end else begin
        out_stall_i = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, with random idle cycles ahead of it. Called and
  // returns at a falling edge; valid stays high into the next item.
  task automatic send_item(input logic ch, input logic signed [7:0] lvl,
                           input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    channel_i  = ch;
    level_db_i = lvl;
    time_ms_i  = t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Wait until every predicted draw has come out, then give items that
  // draw nothing time to leave the block before the config changes.
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // One random phase: new settings, then items that walk the level up and
  // down, switching channel at random, with time steps around the hold and step
  // times so that the peak dot both holds and falls. A few items are noise.
  task automatic run_phase(input logic [CfgDataW-1:0] mode_data,
                           input logic [CfgDataW-1:0] hold, input logic [CfgDataW-1:0] step,
                           input int send_pct, input int recv_pct, input int n_items,
                           input bit fill_up);
    int                i;
    int                dt;
    logic signed [7:0] lvl;
    settle();
    write_reg(RegPeakHold, hold);
    write_reg(RegPeakStep, step);
    write_reg(RegMode, mode_data);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (fill_up) hold_req++;
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(3) == 0) walk_ch = ~walk_ch;
      if ($urandom_range(9) == 0) begin
        lvl = 8'($urandom_range(255));
      end else begin
        lvl_walk = lvl_walk + int'($urandom_range(12)) - 6;
        if (lvl_walk < -60) lvl_walk = -60;
        if (lvl_walk > 15) lvl_walk = 15;
        lvl = 8'(lvl_walk);
      end
      if ($urandom_range(24) == 0) begin
        now_ms = $urandom();
      end else begin
        if ($urandom_range(7) == 0)
          dt = $urandom_range(int'(hold) + int'(hold) / 4 + 3);
        else
          dt = $urandom_range(2 * int'(step) + 3);
        now_ms = now_ms + 32'(dt);
      end
      send_item(walk_ch, lvl, now_ms);
    end
  endtask

  initial begin
    logic [31:0] t0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = RegMode;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    channel_i      = 1'b0;
    level_db_i     = '0;
    time_ms_i      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    walk_ch        = 1'b0;
    lvl_walk       = -20;
    now_ms         = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Column only, reset settings: light segment zero, then low levels that
    // map to segment zero and draw nothing.
    send_item(1'b1, 8'sd127, 32'h0000_0000);
    send_item(1'b1, -8'sd128, 32'hFFFF_FFFF);
    send_item(1'b1, -8'sd128, 32'h0000_0000);
    send_item(1'b1, -8'sd46, 32'h0000_0000);

    // Peak mode, short times. Column climbs to the clamped top through all
    // colours; time starts just below the 32-bit wrap.
    settle();
    write_reg(RegPeakHold, 16'd20);
    write_reg(RegPeakStep, 16'd5);
    write_reg(RegMode, 16'd1);
    t0 = 32'hFFFF_FFF0;
    repeat (18) send_item(1'b0, 8'sd127, t0);
    send_item(1'b0, 8'sd6, t0);            // already at the top: nothing drawn
    send_item(1'b0, -8'sd128, t0 + 1);     // drops off the peak segment, no draw
    send_item(1'b0, -8'sd128, t0 + 20);    // elapsed equals hold: dot stays
    send_item(1'b0, -8'sd128, t0 + 21);    // past hold across the wrap: dot falls
    send_item(1'b0, -8'sd128, t0 + 26);    // elapsed equals step: dot stays
    send_item(1'b0, -8'sd128, t0 + 27);    // past step: dot falls again
    send_item(1'b1, 8'sd3, t0 + 27);       // other channel is independent

    // Random phases, each with its own settings and idling
    run_phase(16'h0001, 16'h0000, 16'h0000, 0, 0, 15, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 88, 0, 12, 1'b0);
    settle();
    write_reg(RegUnused, 16'hFFFF);
    run_phase(16'hFFFE, 16'($urandom_range(300)), 16'($urandom_range(60)), 0, 88, 12,
              1'b0);
    run_phase(16'h0001, 16'd40, 16'd8, 29, 29, 12, 1'b0);
    // receiver holds off while the sender keeps pushing
    run_phase(16'h0001, 16'd3, 16'd1, 0, 0, 15, 1'b1);

    settle();
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/vumph_pkg.sv
rtl/core/vumph_front.sv
rtl/core/vumph_queue.sv
rtl/core/vumph_back.sv
rtl/core/vu_meter_peak_hold.sv
tb/vumph_checker.sv
tb/tb_top.sv
